>>> rtl/mwm_pkg.sv
// shared types, widths and register codes for the mecanum wheel mixer
package mwm_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int VEL_W       = 18;
    localparam int GAIN_W      = 20;
    localparam int LIM_W       = 15;
    localparam int RPM_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int ROT_PROD_W  = VEL_W + GAIN_W + 1;
    localparam int ROT_W       = 22;
    localparam int SUM_W       = 23;
    localparam int PROD_W      = SUM_W + GAIN_W + 1;
    localparam int WHL_W       = 27;
    localparam int MAG_W       = WHL_W - 1;
    localparam int NUM_W       = MAG_W + LIM_W;
    localparam int Q_W         = LIM_W;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [GAIN_W-1:0] ROT_GAIN_RST  = 20'd24248;
    localparam logic [GAIN_W-1:0] RPM_RATIO_RST = 20'd157970;
    localparam logic [LIM_W-1:0]  MAX_RPM_RST   = 15'd8000;

    typedef enum logic [1:0] {
        REG_ROT_GAIN  = 2'd0,
        REG_RPM_RATIO = 2'd1,
        REG_MAX_RPM   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] rot_gain;
        logic [GAIN_W-1:0] rpm_ratio;
        logic [LIM_W-1:0]  max_rpm;
    } cfg_t;

    typedef struct packed {
        logic             neg;
        logic [RPM_W-1:0] wlow;
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   quot;
    } whl_t;

    typedef struct packed {
        whl_t [WHEEL_COUNT-1:0] whl;
        logic [MAG_W-1:0]       mx;
    } div_t;

endpackage

>>> rtl/mecanum_wheel_mixer.sv
// top level of the mecanum wheel mixer: config port, pipelines, output register
// throughput: one command per cycle while the output is not stalled
// pipeline: 7 kinematics stages, 15 divider stages, 1 output stage
// every stage holds under backpressure, bubbles are squeezed out of the pipeline
// reset: asynchronous, clears all valid bits and loads the register defaults
module mecanum_wheel_mixer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [55:0]                s_tdata,   // vel_x, vel_y, yaw_rate, zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,   // front_right, front_left, back_left, back_right
    output logic                       m_tuser,   // was_scaled
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mwm_pkg::ADDR_W-1:0] paddr,
    input  logic [mwm_pkg::DATA_W-1:0] pwdata,
    output logic [mwm_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mwm_pkg::*;

    cfg_t  cfg;
    logic  kin_valid, kin_ready;
    div_t  kin_data;
    logic  div_valid, os_rdy;
    div_t  div_data;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [63:0] m_tdata_next;
    logic        m_tuser_reg;
    logic        scaled_next;

    mwm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mwm_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vel_x     ($signed(s_tdata[17:0])),
        .vel_y     ($signed(s_tdata[35:18])),
        .yaw_rate  ($signed(s_tdata[53:36])),
        .out_valid (kin_valid),
        .out_ready (kin_ready),
        .out_data  (kin_data)
    );

    mwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (kin_valid),
        .in_ready  (kin_ready),
        .din       (kin_data),
        .out_valid (div_valid),
        .out_ready (os_rdy),
        .dout      (div_data)
    );

    assign os_rdy = !m_tvalid_reg || m_tready;

    // pick scaled or raw wheel speed
    always_comb
    begin
        logic [RPM_W-1:0] q;
        scaled_next = div_data.mx > MAG_W'(cfg.max_rpm);
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            q = RPM_W'(div_data.whl[i].quot);
            if (scaled_next)
            begin
                m_tdata_next[i*RPM_W +: RPM_W] = div_data.whl[i].neg ? -q : q;
            end
            else
            begin
                m_tdata_next[i*RPM_W +: RPM_W] = div_data.whl[i].wlow;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (os_rdy)
        begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (os_rdy && div_valid)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= scaled_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // input side only stalls when a finished result is held at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // a scaled quotient never reaches the most negative code
    a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000
            && m_tdata[47:32] != 16'h8000 && m_tdata[63:48] != 16'h8000))
        else $error("scaled wheel speed out of range");

    // output valid only rises after the divider offered a result
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(div_valid))
        else $error("output valid without divider result");
`endif

endmodule

>>> rtl/mwm_cfg.sv
// apb register file for gains and speed limit
module mwm_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mwm_pkg::ADDR_W-1:0] paddr,
    input  logic [mwm_pkg::DATA_W-1:0] pwdata,
    output logic [mwm_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output mwm_pkg::cfg_t              cfg
);
    import mwm_pkg::*;

    logic [GAIN_W-1:0] rot_gain_reg;
    logic [GAIN_W-1:0] rpm_ratio_reg;
    logic [LIM_W-1:0]  max_rpm_reg;
    reg_idx_t          idx;
    logic              wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_gain_reg  <= ROT_GAIN_RST;
            rpm_ratio_reg <= RPM_RATIO_RST;
            max_rpm_reg   <= MAX_RPM_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROT_GAIN:  rot_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_RPM_RATIO: rpm_ratio_reg <= pwdata[GAIN_W-1:0];
                REG_MAX_RPM:   max_rpm_reg   <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROT_GAIN:  prdata = DATA_W'(rot_gain_reg);
            REG_RPM_RATIO: prdata = DATA_W'(rpm_ratio_reg);
            REG_MAX_RPM:   prdata = DATA_W'(max_rpm_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.rot_gain  = rot_gain_reg;
    assign cfg.rpm_ratio = rpm_ratio_reg;
    assign cfg.max_rpm   = max_rpm_reg;

endmodule

>>> rtl/mwm_kin.sv
// kinematics pipeline: rotation term, wheel sums, rpm products, magnitudes, peak
module mwm_kin (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mwm_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [mwm_pkg::VEL_W-1:0] vel_x,
    input  logic signed [mwm_pkg::VEL_W-1:0] vel_y,
    input  logic signed [mwm_pkg::VEL_W-1:0] yaw_rate,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mwm_pkg::div_t                    out_data
);
    import mwm_pkg::*;

    localparam int STAGES = 7;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] rdy;

    logic signed [VEL_W-1:0]      vx1_reg, vy1_reg, vx2_reg, vy2_reg;
    logic signed [ROT_PROD_W-1:0] rp1_reg;
    logic signed [ROT_W-1:0]      rot2_reg;
    logic signed [ROT_W-1:0]      rot_next;
    logic signed [SUM_W-1:0]      w3_reg [WHEEL_COUNT];
    logic signed [SUM_W-1:0]      w3_next [WHEEL_COUNT];
    logic signed [PROD_W-1:0]     p4_reg [WHEEL_COUNT];
    logic signed [WHL_W-1:0]      w5_reg [WHEEL_COUNT];
    logic signed [WHL_W-1:0]      w5_next [WHEEL_COUNT];
    logic [WHEEL_COUNT-1:0]       neg6_reg;
    logic [MAG_W-1:0]             mag6_reg [WHEEL_COUNT];
    logic [MAG_W-1:0]             mag_next [WHEEL_COUNT];
    logic [RPM_W-1:0]             wlow6_reg [WHEEL_COUNT];
    div_t                         out7_reg;
    div_t                         out7_next;

    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_data  = out7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // rotation term truncated toward zero
    logic signed [ROT_PROD_W-1:0] rp_sh;
    assign rp_sh    = rp1_reg >>> FRAC_W;
    assign rot_next = rp_sh[ROT_W-1:0]
                    + {{(ROT_W-1){1'b0}}, rp1_reg[ROT_PROD_W-1] & (|rp1_reg[FRAC_W-1:0])};

    // wheel sums
    logic signed [SUM_W-1:0] ex, ey, er;
    assign ex = SUM_W'(vx2_reg);
    assign ey = SUM_W'(vy2_reg);
    assign er = SUM_W'(rot2_reg);
    assign w3_next[0] =  ex + ey + er;
    assign w3_next[1] =  ex - ey + er;
    assign w3_next[2] = -ex - ey + er;
    assign w3_next[3] = -ex + ey - er;

    always_comb
    begin
        logic signed [PROD_W-1:0] sh;
        logic [WHL_W-1:0]         nv;
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            sh         = p4_reg[i] >>> FRAC_W;
            w5_next[i] = sh[WHL_W-1:0]
                       + {{(WHL_W-1){1'b0}},
                          p4_reg[i][PROD_W-1] & (|p4_reg[i][FRAC_W-1:0])};
            nv          = -w5_reg[i];
            mag_next[i] = w5_reg[i][WHL_W-1] ? nv[MAG_W-1:0] : w5_reg[i][MAG_W-1:0];
        end
    end

    // peak magnitude and scaled numerators
    always_comb
    begin
        logic [MAG_W-1:0] m01, m23;
        m01 = (mag6_reg[0] > mag6_reg[1]) ? mag6_reg[0] : mag6_reg[1];
        m23 = (mag6_reg[2] > mag6_reg[3]) ? mag6_reg[2] : mag6_reg[3];
        out7_next.mx = (m01 > m23) ? m01 : m23;
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            out7_next.whl[i].neg  = neg6_reg[i];
            out7_next.whl[i].wlow = wlow6_reg[i];
            out7_next.whl[i].rem  = NUM_W'(mag6_reg[i]) * NUM_W'(cfg.max_rpm);
            out7_next.whl[i].quot = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            vx1_reg <= vel_x;
            vy1_reg <= vel_y;
            rp1_reg <= ROT_PROD_W'(yaw_rate) * ROT_PROD_W'($signed({1'b0, cfg.rot_gain}));
        end
        if (rdy[1])
        begin
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
            rot2_reg <= rot_next;
        end
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            if (rdy[2])
            begin
                w3_reg[i] <= w3_next[i];
            end
            if (rdy[3])
            begin
                p4_reg[i] <= PROD_W'(w3_reg[i]) * PROD_W'($signed({1'b0, cfg.rpm_ratio}));
            end
            if (rdy[4])
            begin
                w5_reg[i] <= w5_next[i];
            end
            if (rdy[5])
            begin
                neg6_reg[i]  <= w5_reg[i][WHL_W-1];
                mag6_reg[i]  <= mag_next[i];
                wlow6_reg[i] <= w5_reg[i][RPM_W-1:0];
            end
        end
        if (rdy[6])
        begin
            out7_reg <= out7_next;
        end
    end

endmodule

>>> rtl/mwm_div.sv
// pipelined restoring divider, one quotient bit per stage for all wheels
module mwm_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mwm_pkg::div_t din,
    output logic          out_valid,
    input  logic          out_ready,
    output mwm_pkg::div_t dout
);
    import mwm_pkg::*;

    logic [Q_W-1:0] v_reg;
    logic [Q_W-1:0] rdy;
    div_t           stg_reg  [Q_W];
    div_t           stg_in   [Q_W];
    div_t           stg_next [Q_W];

    always_comb
    begin
        rdy[Q_W-1] = !v_reg[Q_W-1] || out_ready;
        for (int k = Q_W - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Q_W-1];
    assign dout      = stg_reg[Q_W-1];

    always_comb
    begin
        logic [NUM_W-1:0] dsr;
        logic             take;
        stg_in[0] = din;
        for (int j = 1; j < Q_W; j++)
        begin
            stg_in[j] = stg_reg[j-1];
        end
        for (int j = 0; j < Q_W; j++)
        begin
            stg_next[j] = stg_in[j];
            dsr = NUM_W'(stg_in[j].mx) << (Q_W - 1 - j);
            for (int i = 0; i < WHEEL_COUNT; i++)
            begin
                take = (stg_in[j].whl[i].rem >= dsr);
                if (take)
                begin
                    stg_next[j].whl[i].rem = stg_in[j].whl[i].rem - dsr;
                end
                stg_next[j].whl[i].quot = {stg_in[j].whl[i].quot[Q_W-2:0], take};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < Q_W; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < Q_W; j++)
        begin
            if (rdy[j])
            begin
                stg_reg[j] <= stg_next[j];
            end
        end
    end

endmodule
